FILE: rtl/core/crc32c_string_hash_defines.svh
// assertion macros for the crc32c string hash checker
// expects clk and arst_n in the scope where a macro is used
`ifndef CRC32C_STRING_HASH_DEFINES_SVH
`define CRC32C_STRING_HASH_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define CRCSH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// same-cycle implication
`define CRCSH_IMPLY(lbl, ante, cons, msg) \
	`CRCSH_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/crcsh_pkg.sv
// constants and byte update function for the crc32c string hash
// no dependencies
`default_nettype none

package crcsh_pkg;

	localparam int          DATA_BYTES = 8;
	localparam logic [31:0] CRC_START  = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;

	typedef logic [31:0] crc_t;

	// reflected crc-32c over one byte, lsb first
	function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] byte_v);
		crc_t c;
		c = crc ^ {24'h0, byte_v};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crc32c_string_hash.sv
// crc32c string hash: input register, xor tree, result register
// depends on crcsh_pkg
// flow: input register, xor tree, result register; a stalled result holds both stages
// throughput: one word per cycle unless result_ready stalls, set by the running crc
//   feedback register that closes through the byte xor tree combinationally
// reset: running crc loads all ones, both stages empty
`default_nettype none

module crc32c_string_hash import crcsh_pkg::*; #(
	parameter int BYTES_PER_WORD = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        start_flag,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	input  wire logic        end_flag,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      crc_value,
	output logic             hash_done
);

	logic        valid_s1;
	logic        start_s1;
	logic [63:0] data_s1;
	logic [3:0]  count_s1;
	logic        end_s1;

	logic        valid_s2;
	crc_t        crc_s2;
	logic        done_s2;

	crc_t        running_crc_q;
	crc_t        crc_next;
	logic        advance;

	assign advance    = !valid_s2 || result_ready;
	assign item_ready = !valid_s1 || advance;

	// bytes past the count leave the crc alone, bytes past the data word are zero
	always_comb begin
		logic [7:0] byte_v;
		crc_next = start_s1 ? CRC_START : running_crc_q;
		for (int i = 0; i < BYTES_PER_WORD; i++) begin
			byte_v = (i < DATA_BYTES) ? data_s1[8*(i % DATA_BYTES) +: 8] : 8'h00;
			if (i < int'(count_s1)) begin
				crc_next = crc_byte(crc_next, byte_v);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			running_crc_q <= CRC_START;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && advance) begin
				running_crc_q <= crc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			start_s1 <= start_flag;
			data_s1  <= data_word;
			count_s1 <= byte_count;
			end_s1   <= end_flag;
		end
		if (valid_s1 && advance) begin
			crc_s2  <= crc_next;
			done_s2 <= end_s1;
		end
	end

	assign result_valid = valid_s2;
	assign crc_value    = crc_s2;
	assign hash_done    = done_s2;

endmodule

`default_nettype wire

FILE: rtl/core/crcsh_checker.sv
// port-level checks for crc32c_string_hash, bound to the top level
// depends on crcsh_pkg and crc32c_string_hash_defines.svh
`default_nettype none
`include "crc32c_string_hash_defines.svh"

module crcsh_checker import crcsh_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        start_flag,
	input wire logic [3:0]  byte_count,
	input wire logic        end_flag,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [31:0] crc_value,
	input wire logic        hash_done
);

	logic       in_beat;
	logic       out_beat;
	logic [1:0] fill_q;
	logic       wr_q;
	logic       rd_q;
	logic [1:0] exp_done_q;
	logic [1:0] exp_ones_q;

	assign in_beat  = item_valid && item_ready;
	assign out_beat = result_valid && result_ready;

	// expected flags of beats in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= 2'd0;
			wr_q       <= 1'b0;
			rd_q       <= 1'b0;
			exp_done_q <= 2'b00;
			exp_ones_q <= 2'b00;
		end else begin
			fill_q <= fill_q + {1'b0, in_beat} - {1'b0, out_beat};
			if (in_beat) begin
				exp_done_q[wr_q] <= end_flag;
				exp_ones_q[wr_q] <= start_flag && (byte_count == 4'd0);
				wr_q             <= !wr_q;
			end
			if (out_beat) begin
				rd_q <= !rd_q;
			end
		end
	end

	`CRCSH_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(crc_value) && $stable(hash_done), "result beat changed while stalled")
	`CRCSH_IMPLY(a_no_ghost, result_valid, fill_q != 2'd0, "result beat without an input beat")
	`CRCSH_IMPLY(a_done_order, result_valid, hash_done == exp_done_q[rd_q], "done flag out of order")
	`CRCSH_IMPLY(a_empty_start, result_valid && exp_ones_q[rd_q], crc_value == CRC_START, "empty start word not all ones")

endmodule

bind crc32c_string_hash crcsh_checker u_crcsh_checker (.*);

`default_nettype wire
